### rtl/core/ipv6_lpm_pkg.sv
// ----------------------------------------------------------------------------
// IPv6 LPM package
// Shared sizes, request and response records and trie node layout for the
// longest prefix match trie core.
// ----------------------------------------------------------------------------
`default_nettype none

package ipv6_lpm_pkg;

   localparam int NODE_COUNT    = 4096;
   localparam int ADDR_BITS     = 128;
   localparam int ID_BITS       = 16;
   localparam int LEN_BITS      = 8;
   localparam int NODE_IDX_BITS = $clog2(NODE_COUNT);
   localparam int COUNT_BITS    = NODE_IDX_BITS + 1;

   localparam logic OP_INSERT   = 1'b0;
   localparam logic OP_LOOKUP   = 1'b1;
   localparam logic STATUS_DONE = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef struct packed {
      logic                opcode;
      logic [63:0]         addr_high;
      logic [63:0]         addr_low;
      logic [LEN_BITS-1:0] prefix_len;
      logic [15:0]         dest_id;
   } req_type;

   typedef struct packed {
      logic                status;
      logic                found;
      logic [15:0]         match_id;
      logic [LEN_BITS-1:0] match_len;
   } rsp_type;

   typedef struct packed {
      logic [NODE_IDX_BITS-1:0] kid0;
      logic [NODE_IDX_BITS-1:0] kid1;
      logic                     valid;
      logic [ID_BITS-1:0]       id;
   } node_type;

   localparam int NODE_BITS = $bits(node_type);

endpackage

`default_nettype wire

### rtl/core/ipv6_lpm_if.sv
// ----------------------------------------------------------------------------
// IPv6 LPM channels
// Valid/ready channels that carry requests into the trie core and responses
// out of it.
// ----------------------------------------------------------------------------
`default_nettype none

interface ipv6_lpm_req_if;
   import ipv6_lpm_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface ipv6_lpm_rsp_if;
   import ipv6_lpm_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/ipv6_lpm_ram.sv
// ----------------------------------------------------------------------------
// IPv6 LPM RAM
// Generic simple dual-port RAM with one write port and a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_lpm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

`default_nettype wire

### rtl/core/ipv6_longest_prefix_match_trie_core.sv
// ----------------------------------------------------------------------------
// IPv6 longest prefix match trie core
// Binary trie with one address bit per level. Inserts allocate nodes from a
// bounded pool; lookups return the deepest stored id along the address path.
//
//   Channel   Direction  Handshake        Contents
//   req_ch    in         valid / ready    opcode, address, prefix_len, dest_id
//   rsp_ch    out        valid / ready    status, found, match_id, match_len
//
// A request is accepted in IDLE, walks the trie in WALK one level at a time and loads
// the response register in RESULT. The walk does one node RAM read or write per level,
// with the address shifted out one bit per cycle. One request is in work at a time; the
// next is taken while the previous response still waits. Reset is synchronous and empties
// the trie at once, and a stalled response holds the core in its RESULT state.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_longest_prefix_match_trie_core (
   input wire logic       clock,
   input wire logic       reset,
   ipv6_lpm_req_if.sink   req_ch,
   ipv6_lpm_rsp_if.source rsp_ch
);
   import ipv6_lpm_pkg::*;

   typedef enum logic [2:0] {
      IDLE   = 3'b001,
      WALK   = 3'b010,
      RESULT = 3'b100
   } state_type;

   state_type                state_ff, state_in;
   logic [NODE_IDX_BITS-1:0] root_kid0_ff, root_kid0_in;
   logic [NODE_IDX_BITS-1:0] root_kid1_ff, root_kid1_in;
   logic                     root_valid_ff, root_valid_in;
   logic [ID_BITS-1:0]       root_id_ff, root_id_in;
   logic [COUNT_BITS-1:0]    next_free_ff, next_free_in;

   logic                     op_ff, op_in;
   logic [ADDR_BITS-1:0]     addr_ff, addr_in;
   logic [LEN_BITS-1:0]      plen_ff, plen_in;
   logic [ID_BITS-1:0]       id_ff, id_in;
   logic [NODE_IDX_BITS-1:0] cur_ff, cur_in;
   logic [LEN_BITS-1:0]      depth_ff, depth_in;
   logic                     fresh_ff, fresh_in;
   logic                     status_ff, status_in;
   logic                     found_ff, found_in;
   logic [ID_BITS-1:0]       mid_ff, mid_in;
   logic [LEN_BITS-1:0]      mlen_ff, mlen_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   logic                     ram_we;
   node_type                 ram_wdata;
   logic [NODE_BITS-1:0]     ram_rdata;
   node_type                 node_cur;
   logic                     addr_bit;
   logic [NODE_IDX_BITS-1:0] child;
   logic [NODE_IDX_BITS-1:0] new_node;

   ipv6_lpm_ram #(
      .WIDTH (NODE_BITS),
      .DEPTH (NODE_COUNT)
   ) u_node_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (cur_ff),
      .wr_data (ram_wdata),
      .rd_addr (cur_in),
      .rd_data (ram_rdata)
   );

   assign req_ch.ready = (state_ff == IDLE);
   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

   // The root lives in registers; a freshly allocated node is known to be empty.
   always_comb begin
      if (cur_ff == '0) begin
         node_cur = '{kid0: root_kid0_ff, kid1: root_kid1_ff,
                      valid: root_valid_ff, id: root_id_ff};
      end else if (fresh_ff) begin
         node_cur = '0;
      end else begin
         node_cur = node_type'(ram_rdata);
      end
   end

   assign addr_bit = addr_ff[ADDR_BITS-1];
   assign child    = addr_bit ? node_cur.kid1 : node_cur.kid0;
   assign new_node = next_free_ff[NODE_IDX_BITS-1:0];

   always_comb begin
      state_in      = state_ff;
      root_kid0_in  = root_kid0_ff;
      root_kid1_in  = root_kid1_ff;
      root_valid_in = root_valid_ff;
      root_id_in    = root_id_ff;
      next_free_in  = next_free_ff;
      op_in         = op_ff;
      addr_in       = addr_ff;
      plen_in       = plen_ff;
      id_in         = id_ff;
      cur_in        = cur_ff;
      depth_in      = depth_ff;
      fresh_in      = fresh_ff;
      status_in     = status_ff;
      found_in      = found_ff;
      mid_in        = mid_ff;
      mlen_in       = mlen_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_data_in   = rsp_data_ff;
      ram_we        = 1'b0;
      ram_wdata     = node_cur;

      case (state_ff)
         IDLE: begin
            if (req_ch.valid) begin
               op_in     = req_ch.data.opcode;
               addr_in   = {req_ch.data.addr_high, req_ch.data.addr_low};
               plen_in   = (req_ch.data.prefix_len > LEN_BITS'(ADDR_BITS)) ?
                           LEN_BITS'(ADDR_BITS) : req_ch.data.prefix_len;
               id_in     = req_ch.data.dest_id[ID_BITS-1:0];
               cur_in    = '0;
               depth_in  = '0;
               fresh_in  = 1'b0;
               status_in = STATUS_DONE;
               found_in  = 1'b0;
               mid_in    = '0;
               mlen_in   = '0;
               state_in  = WALK;
            end
         end

         WALK: begin
            if (op_ff == OP_LOOKUP) begin
               if (node_cur.valid) begin
                  found_in = 1'b1;
                  mid_in   = node_cur.id;
                  mlen_in  = depth_ff;
               end
               if (depth_ff == LEN_BITS'(ADDR_BITS) || child == '0) begin
                  state_in = RESULT;
               end else begin
                  cur_in   = child;
                  depth_in = depth_ff + 1'b1;
                  addr_in  = {addr_ff[ADDR_BITS-2:0], 1'b0};
               end
            end else if (depth_ff == plen_ff) begin
               if (cur_ff == '0) begin
                  root_valid_in = 1'b1;
                  root_id_in    = id_ff;
               end else begin
                  ram_we          = 1'b1;
                  ram_wdata.valid = 1'b1;
                  ram_wdata.id    = id_ff;
               end
               state_in = RESULT;
            end else if (child != '0) begin
               cur_in   = child;
               fresh_in = 1'b0;
               depth_in = depth_ff + 1'b1;
               addr_in  = {addr_ff[ADDR_BITS-2:0], 1'b0};
            end else if (next_free_ff == COUNT_BITS'(NODE_COUNT)) begin
               // A node linked in this request but never written must still
               // read back as empty later on.
               status_in = STATUS_FULL;
               if (fresh_ff && cur_ff != '0) begin
                  ram_we = 1'b1;
               end
               state_in = RESULT;
            end else begin
               next_free_in = next_free_ff + 1'b1;
               if (cur_ff == '0) begin
                  if (addr_bit) begin
                     root_kid1_in = new_node;
                  end else begin
                     root_kid0_in = new_node;
                  end
               end else begin
                  ram_we = 1'b1;
                  if (addr_bit) begin
                     ram_wdata.kid1 = new_node;
                  end else begin
                     ram_wdata.kid0 = new_node;
                  end
               end
               cur_in   = new_node;
               fresh_in = 1'b1;
               depth_in = depth_ff + 1'b1;
               addr_in  = {addr_ff[ADDR_BITS-2:0], 1'b0};
            end
         end

         RESULT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = '{status: status_ff, found: found_ff,
                                match_id: 16'(mid_ff), match_len: mlen_ff};
               state_in     = IDLE;
            end
         end

         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         root_kid0_ff  <= '0;
         root_kid1_ff  <= '0;
         root_valid_ff <= 1'b0;
         root_id_ff    <= '0;
         next_free_ff  <= COUNT_BITS'(1);
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         root_kid0_ff  <= root_kid0_in;
         root_kid1_ff  <= root_kid1_in;
         root_valid_ff <= root_valid_in;
         root_id_ff    <= root_id_in;
         next_free_ff  <= next_free_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      addr_ff     <= addr_in;
      plen_ff     <= plen_in;
      id_ff       <= id_in;
      cur_ff      <= cur_in;
      depth_ff    <= depth_in;
      fresh_ff    <= fresh_in;
      status_ff   <= status_in;
      found_ff    <= found_in;
      mid_ff      <= mid_in;
      mlen_ff     <= mlen_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

### rtl/core/ipv6_lpm_checker.sv
// ----------------------------------------------------------------------------
// IPv6 LPM checker
// Port-level checks on the trie core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module ipv6_lpm_checker (
   input wire logic                         clock,
   input wire logic                         reset,
   input wire logic                         req_valid,
   input wire logic                         req_ready,
   input wire logic                         rsp_valid,
   input wire logic                         rsp_ready,
   input wire ipv6_lpm_pkg::rsp_type        rsp_data
);
   import ipv6_lpm_pkg::*;

   // A stalled response keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Only one request is in work at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while another is in work");

   // A response never appears in the cycle right after its request.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early");

   // Without a match, the id and length are zero and a full pool never matches.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.status == STATUS_FULL || !rsp_data.found) |->
         rsp_data.match_id == '0 && rsp_data.match_len == '0 && !rsp_data.found)
      else $error("empty match carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.match_len <= LEN_BITS'(ADDR_BITS))
      else $error("match length out of range");

endmodule

bind ipv6_longest_prefix_match_trie_core ipv6_lpm_checker u_ipv6_lpm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_data  (rsp_ch.data)
);

`default_nettype wire

### bench/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// IPv6 longest prefix match trie core testbench
// Sends insert and lookup requests through the valid/ready request channel
// and checks every response against a behavioral trie held in the bench.
// Directed requests cover the empty trie, the root prefix, full-length and
// clamped prefixes and id overwrites. Random phases then grow prefixes out of
// earlier ones under varied idle and stall patterns, and a last phase drains
// the node pool so that inserts are rejected.
// ----------------------------------------------------------------------------

module tb_top;
   import ipv6_lpm_pkg::*;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int TAIL_CYCLES = 200;

   logic clock;
   logic reset;

   ipv6_lpm_req_if req_ch ();
   ipv6_lpm_rsp_if rsp_ch ();

   ipv6_longest_prefix_match_trie_core u_top (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // Behavioral trie. Index 0 holds the root's children and the root entry.
   bit [NODE_IDX_BITS-1:0] kid_zero [NODE_COUNT];
   bit [NODE_IDX_BITS-1:0] kid_one  [NODE_COUNT];
   bit                     node_has_id [NODE_COUNT];
   bit [ID_BITS-1:0]       node_id [NODE_COUNT];
   int unsigned            free_node;

   req_type      request_backlog [$];
   rsp_type      pending_answers [$];
   logic [127:0] known_prefix [$];
   int           known_len [$];

   bit pause_sender;
   bit req_accepted;
   int send_idle_pct;
   int rsp_stall_pct;
   int long_budget;
   int cycle_count;
   int error_count;
   int insert_count;
   int reject_count;
   int lookup_count;
   int hit_count;

   function automatic rsp_type walk_trie(req_type r);
      rsp_type                res;
      logic [127:0]           path;
      int                     plen;
      int                     step;
      int unsigned            cur;
      bit [NODE_IDX_BITS-1:0] nxt;
      bit                     ok;
      bit                     go;
      res  = '0;
      path = {r.addr_high, r.addr_low};
      cur  = 0;
      if (r.opcode == OP_INSERT) begin
         plen = (r.prefix_len > ADDR_BITS) ? ADDR_BITS : int'(r.prefix_len);
         ok   = 1'b1;
         for (step = 0; step < plen && ok; step++) begin
            nxt = path[127 - step] ? kid_one[cur] : kid_zero[cur];
            if (nxt == 0) begin
               if (free_node >= NODE_COUNT) begin
                  ok = 1'b0;
               end else begin
                  nxt = free_node[NODE_IDX_BITS-1:0];
                  free_node++;
                  kid_zero[nxt]    = '0;
                  kid_one[nxt]     = '0;
                  node_has_id[nxt] = 1'b0;
                  node_id[nxt]     = '0;
                  if (path[127 - step]) begin
                     kid_one[cur] = nxt;
                  end else begin
                     kid_zero[cur] = nxt;
                  end
               end
            end
            if (ok) begin
               cur = nxt;
            end
         end
         if (ok) begin
            node_has_id[cur] = 1'b1;
            node_id[cur]     = r.dest_id[ID_BITS-1:0];
            res.status       = STATUS_DONE;
         end else begin
            res.status = STATUS_FULL;
         end
      end else begin
         if (node_has_id[0]) begin
            res.found    = 1'b1;
            res.match_id = node_id[0];
         end
         go = 1'b1;
         for (step = 0; step < ADDR_BITS && go; step++) begin
            nxt = path[127 - step] ? kid_one[cur] : kid_zero[cur];
            if (nxt == 0) begin
               go = 1'b0;
            end else begin
               cur = nxt;
               if (node_has_id[cur]) begin
                  res.found     = 1'b1;
                  res.match_id  = node_id[cur];
                  res.match_len = LEN_BITS'(step + 1);
               end
            end
         end
      end
      return res;
   endfunction

   function automatic logic [127:0] rand128();
      return {$urandom(), $urandom(), $urandom(), $urandom()};
   endfunction

   // Keeps the leading len bits of prefix and fills the rest from fill.
   function automatic logic [127:0] keep_top(logic [127:0] prefix, int len,
                                             logic [127:0] fill);
      logic [127:0] mask;
      mask = (len == 0) ? '0 : ~((128'd1 << (128 - len)) - 128'd1);
      return (prefix & mask) | (fill & ~mask);
   endfunction

   task automatic push_insert(input logic [127:0] addr, input int len,
                              input logic [15:0] id);
      req_type item;
      item.opcode     = OP_INSERT;
      item.addr_high  = addr[127:64];
      item.addr_low   = addr[63:0];
      item.prefix_len = LEN_BITS'(len);
      item.dest_id    = id;
      request_backlog.push_back(item);
      known_prefix.push_back(addr);
      known_len.push_back((len > ADDR_BITS) ? ADDR_BITS : len);
   endtask

   task automatic push_lookup(input logic [127:0] addr);
      req_type item;
      item.opcode     = OP_LOOKUP;
      item.addr_high  = addr[127:64];
      item.addr_low   = addr[63:0];
      item.prefix_len = LEN_BITS'($urandom());
      item.dest_id    = 16'($urandom());
      request_backlog.push_back(item);
   endtask

   task automatic wait_drain();
      while (request_backlog.size() != 0 || req_ch.valid || pending_answers.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic add_random_items(input int count);
      int           k;
      int           sel;
      int           pick;
      int           len;
      int           depth;
      logic [127:0] base;
      for (k = 0; k < count; k++) begin
         sel  = $urandom_range(99);
         pick = $urandom_range(known_prefix.size() - 1);
         base = known_prefix[pick];
         len  = known_len[pick];
         if (sel < 30) begin
            push_lookup(keep_top(base, len, rand128()));
         end else if (sel < 40) begin
            push_lookup(keep_top(base, len, rand128()) ^ (128'd1 << $urandom_range(127)));
         end else if (sel < 50) begin
            push_lookup(rand128());
         end else if (sel < 70) begin
            depth = len + $urandom_range(1, 6);
            push_insert(keep_top(base, len, rand128()), (depth > 128) ? 128 : depth,
                        16'($urandom()));
         end else if (sel < 80 && len > 0) begin
            depth = len - 1 - $urandom_range((len > 4) ? 3 : len - 1);
            push_insert(base ^ (128'd1 << (127 - depth)), len, 16'($urandom()));
         end else if (sel < 88) begin
            push_insert(base, len, 16'($urandom()));
         end else if (sel < 97 || long_budget == 0 || free_node > 2000) begin
            push_insert(rand128(), $urandom_range(0, 20), 16'($urandom()));
         end else begin
            long_budget--;
            push_insert(rand128(), $urandom_range(100, 255), 16'($urandom()));
         end
      end
   endtask

   task automatic run_phase(input int idx, input int count);
      case (idx % 4)
         0: begin
            send_idle_pct = 0;
            rsp_stall_pct = 0;
         end
         1: begin
            send_idle_pct = 51;
            rsp_stall_pct = 0;
         end
         2: begin
            send_idle_pct = 0;
            rsp_stall_pct = 51;
         end
         default: begin
            send_idle_pct = 17;
            rsp_stall_pct = 17;
         end
      endcase
      long_budget = 3;
      if (idx == 2) begin
         add_random_items(count / 2);
         while (request_backlog.size() > count / 4) begin
            @(posedge clock);
         end
         pause_sender = 1'b1;
         while (req_ch.valid || pending_answers.size() != 0) begin
            @(posedge clock);
         end
         pause_sender = 1'b0;
         add_random_items(count - count / 2);
      end else begin
         add_random_items(count);
      end
      wait_drain();
   endtask

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("ipv6_longest_prefix_match_trie_core test failed");
         $finish;
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
         rsp_ch.ready <= 1'b0;
      end else begin
         if (!req_ch.valid || req_accepted) begin
            if (!pause_sender && request_backlog.size() != 0 &&
                $urandom_range(99) >= send_idle_pct) begin
               req_ch.valid <= 1'b1;
               req_ch.data  <= request_backlog.pop_front();
            end else begin
               req_ch.valid <= 1'b0;
            end
         end
         rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         req_accepted = 1'b0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (pending_answers.size() == 0) begin
               $error("response with no request outstanding");
               error_count++;
            end else begin
               want = pending_answers.pop_front();
               if (rsp_ch.data.status !== want.status) begin
                  $error("status: expected %0h, got %0h", want.status, rsp_ch.data.status);
                  error_count++;
               end
               if (rsp_ch.data.found !== want.found) begin
                  $error("found: expected %0h, got %0h", want.found, rsp_ch.data.found);
                  error_count++;
               end
               if (rsp_ch.data.match_id !== want.match_id) begin
                  $error("match_id: expected %0h, got %0h", want.match_id,
                         rsp_ch.data.match_id);
                  error_count++;
               end
               if (rsp_ch.data.match_len !== want.match_len) begin
                  $error("match_len: expected %0d, got %0d", want.match_len,
                         rsp_ch.data.match_len);
                  error_count++;
               end
               if (want.status == STATUS_FULL) begin
                  reject_count++;
               end
               if (want.found) begin
                  hit_count++;
               end
            end
         end
         req_accepted = req_ch.valid && req_ch.ready;
         if (req_accepted) begin
            pending_answers.push_back(walk_trie(req_ch.data));
            if (req_ch.data.opcode == OP_INSERT) begin
               insert_count++;
            end else begin
               lookup_count++;
            end
         end
      end
   end

   initial begin
      int k;
      req_ch.valid  = 1'b0;
      req_ch.data   = '0;
      rsp_ch.ready  = 1'b0;
      reset         = 1'b1;
      pause_sender  = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      long_budget   = 0;
      cycle_count   = 0;
      error_count   = 0;
      insert_count  = 0;
      reject_count  = 0;
      lookup_count  = 0;
      hit_count     = 0;
      free_node     = 1;
      foreach (kid_zero[n]) begin
         kid_zero[n]    = '0;
         kid_one[n]     = '0;
         node_has_id[n] = 1'b0;
         node_id[n]     = '0;
      end
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_lookup({128{1'b1}});
      push_insert(rand128(), 0, 16'h1234);
      push_lookup(rand128());
      push_insert('0, 128, 16'hffff);
      push_insert({128{1'b1}}, 255, 16'h0000);
      push_lookup('0);
      push_lookup({128{1'b1}});
      push_insert('0, 64, 16'haaaa);
      push_lookup(128'd1);
      push_insert({1'b1, 127'd0}, 1, 16'h5555);
      push_insert(rand128(), 0, 16'hbeef);
      push_lookup({2'b01, 126'd0});
      push_lookup({2'b10, {126{1'b1}}});
      push_insert({64'h2001_0db8_85a3_0000, 64'h0000_8a2e_0370_7334}, 129, 16'h0001);
      push_lookup({64'h2001_0db8_85a3_0000, 64'h0000_8a2e_0370_7334});
      push_lookup({64'h2001_0db8_85a3_0000, 64'h0000_8a2e_0370_7335});
      push_insert({64'h2001_0db8_0000_0000, 64'h0}, 32, 16'h8001);
      push_lookup({64'h2001_0db8_ffff_0000, 64'h1});
      push_insert(rand128(), 200, 16'h7ffe);
      push_insert('0, 64, 16'h0f0f);
      push_lookup({64'h0, 64'h0000_0000_0000_ffff});
      wait_drain();

      for (k = 0; k < 6; k++) begin
         run_phase(k, 185);
      end

      // Fill the node pool with unrelated full-length prefixes until it runs dry.
      send_idle_pct = 17;
      rsp_stall_pct = 17;
      while (free_node < NODE_COUNT) begin
         repeat (4) push_insert(rand128(), 128, 16'($urandom()));
         push_lookup(keep_top(known_prefix[known_prefix.size() - 1], 128, '0));
         push_lookup(rand128());
         wait_drain();
      end
      for (k = 0; k < 4; k++) begin
         push_insert(rand128(), $urandom_range(64, 255), 16'($urandom()));
         push_insert(known_prefix[$urandom_range(known_prefix.size() - 1)],
                     known_len[$urandom_range(known_len.size() - 1)], 16'($urandom()));
         push_lookup(keep_top(known_prefix[k], known_len[k], rand128()));
         push_lookup(rand128());
      end
      wait_drain();

      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_answers.size() != 0) begin
         $error("%0d responses never arrived", pending_answers.size());
         error_count++;
      end
      $display("Ran %0d inserts (%0d refused on a full pool) and %0d lookups (%0d matched).",
               insert_count, reject_count, lookup_count, hit_count);
      $display("Node pool use at the end: %0d of %0d nodes.", free_node, NODE_COUNT);
      if (error_count == 0) begin
         $display("ipv6_longest_prefix_match_trie_core test passed");
      end else begin
         $display("ipv6_longest_prefix_match_trie_core test failed");
      end
      $finish;
   end

endmodule
